// File: sv/mced_pkg.sv
// ----------------------------------------------------------------------------
// mced_pkg: shared types for the multi-channel edge debouncer
// Channel state codes, result status codes, register indexes and the
// per-channel memory entry layout.
// ----------------------------------------------------------------------------
package mced_pkg;

    typedef enum logic [1:0]
    {
        BTN_LOW  = 2'd0,
        BTN_HIGH = 2'd1,
        BTN_FALL = 2'd2,
        BTN_RISE = 2'd3
    } btn_state_t;

    typedef enum logic [1:0]
    {
        STAT_OK       = 2'd0,
        STAT_DISABLED = 2'd1,
        STAT_RANGE    = 2'd2
    } status_t;

    localparam logic [1:0] REG_ENABLED       = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_REPEAT_COUNT  = 2'd2;

    localparam int unsigned CNT_W = 8;

    typedef struct packed
    {
        btn_state_t       state;
        logic [CNT_W-1:0] count;
    } chan_entry_t;

    localparam chan_entry_t ENTRY_RESET = '{state: BTN_HIGH, count: '0};

endpackage

// File: sv/mced_store.sv
// ----------------------------------------------------------------------------
// mced_store: per-channel state memory
// One synchronous memory with a registered read, per-entry valid bits that
// make unwritten entries read as the reset value, and forwarding of a write
// that lands on the same edge as a read of the same entry.
// ----------------------------------------------------------------------------
module mced_store
    import mced_pkg::*;
#(
    parameter int CHANNELS = 8,
    parameter int IDX_W    = 3
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  chan_entry_t      wr_data,
    output chan_entry_t      rd_data
);

    chan_entry_t           mem [CHANNELS];
    chan_entry_t           mem_q_reg;
    logic [CHANNELS-1:0]   vld_reg;
    logic                  rd_vld_reg;
    logic                  fwd_hit_reg;
    chan_entry_t           fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg  <= vld_reg[rd_addr];
                // The memory returns the old word when a write hits the same
                // entry on the read edge, so that write is taken from here.
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (rd_vld_reg)
        begin
            rd_data = mem_q_reg;
        end
        else
        begin
            rd_data = ENTRY_RESET;
        end
    end

endmodule

// File: sv/multi_channel_edge_debouncer_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_edge_debouncer_unit: counter-based edge debouncer
// Timing: memory is read at the edge that accepts a sample; the update is
// registered into the output register when the update stage advances.
// Throughput: one sample per cycle while the result stream does not stall;
// the channel memory is read and written once per cycle, with same-entry
// forwarding between neighbors.
// Reset: registers return to enabled 0, channel_count 0, repeat_count 4, and
// every channel reads as steady high with a zero counter at once.
// ----------------------------------------------------------------------------
module multi_channel_edge_debouncer_unit
    import mced_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] channel, [3] level, [7:4] zero
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] button_state, [3:2] status, [7:4] zero
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers
    logic       enabled_reg;
    logic [3:0] chan_cnt_reg;
    logic [7:0] repeat_reg;

    // Update stage
    logic       s1_valid_reg;
    logic [2:0] s1_chan_reg;
    logic       s1_level_reg;

    // Output register
    logic       out_valid_reg;
    btn_state_t out_state_reg;
    status_t    out_status_reg;

    logic        in_accept;
    logic        s1_advance;
    logic        cfg_write;
    logic        in_range;
    logic        wr_en;
    chan_entry_t cur_entry;
    chan_entry_t new_entry;
    btn_state_t  steady;
    btn_state_t  res_state;
    status_t     res_status;
    logic [7:0]  cnt_inc;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= 1'b0;
            chan_cnt_reg <= 4'd0;
            repeat_reg   <= 8'd4;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ENABLED:       enabled_reg  <= pwdata[0];
                REG_CHANNEL_COUNT: chan_cnt_reg <= pwdata[3:0];
                REG_REPEAT_COUNT:  repeat_reg   <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLED:       prdata = {31'd0, enabled_reg};
            REG_CHANNEL_COUNT: prdata = {28'd0, chan_cnt_reg};
            REG_REPEAT_COUNT:  prdata = {24'd0, repeat_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Handshakes
    assign s1_advance = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_accept  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_chan_reg  <= s_tdata[2:0];
            s1_level_reg <= s_tdata[3];
        end
        if (s1_advance)
        begin
            out_state_reg  <= res_state;
            out_status_reg <= res_status;
        end
    end

    mced_store #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (IDX_W'(s_tdata[2:0])),
        .wr_en   (wr_en),
        .wr_addr (IDX_W'(s1_chan_reg)),
        .wr_data (new_entry),
        .rd_data (cur_entry)
    );

    // Channel update
    assign in_range = ({1'b0, s1_chan_reg} < chan_cnt_reg) && (int'(s1_chan_reg) < CHANNELS);
    assign wr_en    = s1_advance && enabled_reg && in_range;
    assign cnt_inc  = cur_entry.count + 8'd1;

    always_comb
    begin
        case (cur_entry.state)
            BTN_FALL: steady = BTN_LOW;
            BTN_RISE: steady = BTN_HIGH;
            default:  steady = cur_entry.state;
        endcase

        new_entry.state = steady;
        if (s1_level_reg == (steady == BTN_HIGH))
        begin
            new_entry.count = 8'd0;
        end
        else if (cnt_inc == repeat_reg)
        begin
            new_entry.state = (steady == BTN_HIGH) ? BTN_FALL : BTN_RISE;
            new_entry.count = 8'd0;
        end
        else
        begin
            new_entry.count = cnt_inc;
        end

        if (!enabled_reg)
        begin
            res_state  = BTN_LOW;
            res_status = STAT_DISABLED;
        end
        else if (!in_range)
        begin
            res_state  = BTN_LOW;
            res_status = STAT_RANGE;
        end
        else
        begin
            res_state  = new_entry.state;
            res_status = STAT_OK;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_status_reg, out_state_reg};

endmodule

// File: tb/tb_multi_channel_edge_debouncer_unit.sv
// ----------------------------------------------------------------------------
// tb_multi_channel_edge_debouncer_unit: self-checking regression
// Drives pin samples into the debouncer through the sample stream and checks
// every result against a cycle-free model of the per-channel state machine.
// Covers directed corner cases, a repeat count lowered to zero below a running
// counter so that the counter wraps, and random bursts with random stalls on
// both streams.
// ----------------------------------------------------------------------------
module tb_multi_channel_edge_debouncer_unit;
    import mced_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_CH     = 8;
    localparam int CYCLE_CAP  = 400000;

    typedef struct packed
    {
        status_t    stat;
        btn_state_t st;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [2:0] channel, [3] level, [7:4] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [1:0] button_state, [3:2] status, [7:4] zero

    // Model of the channel table and the registers.
    btn_state_t  chan_state [NUM_CH];
    logic [7:0]  chan_miss [NUM_CH];
    logic        cfg_enabled;
    logic [3:0]  cfg_channels;
    logic [7:0]  cfg_repeat;

    result_t     expected_results[$];
    result_t     want;
    int          error_count;
    int          cycle_count;
    bit          no_gap;
    bit          no_stall;

    multi_channel_edge_debouncer_unit #(.CHANNELS(NUM_CH)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic btn_state_t steady_of(input btn_state_t s);
        if (s == BTN_FALL)
            return BTN_LOW;
        else if (s == BTN_RISE)
            return BTN_HIGH;
        return s;
    endfunction

    function automatic logic steady_level(input int ch);
        return (steady_of(chan_state[ch]) == BTN_HIGH);
    endfunction

    // Applies one sample to the model and returns the result it must produce.
    function automatic result_t debounce_predict(input logic [2:0] ch, input logic lvl);
        result_t    r;
        btn_state_t s;
        r.st   = BTN_LOW;
        r.stat = STAT_OK;
        if (!cfg_enabled)
            r.stat = STAT_DISABLED;
        else if ({1'b0, ch} >= cfg_channels)
            r.stat = STAT_RANGE;
        else
        begin
            s = steady_of(chan_state[ch]);
            if (lvl == (s == BTN_HIGH))
                chan_miss[ch] = 8'd0;
            else
            begin
                chan_miss[ch] = chan_miss[ch] + 8'd1;
                if (chan_miss[ch] == cfg_repeat)
                begin
                    if (s == BTN_HIGH)
                        s = BTN_FALL;
                    else
                        s = BTN_RISE;
                    chan_miss[ch] = 8'd0;
                end
            end
            chan_state[ch] = s;
            r.st = s;
        end
        return r;
    endfunction

    // Result checker and predictor hook, both on accepted transactions.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %h", $time, m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] != want.st)
                    begin
                        $display("%0t: button_state expected %0d actual %0d",
                                 $time, want.st, m_tdata[1:0]);
                        error_count++;
                    end
                    if (m_tdata[3:2] != want.stat)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.stat, m_tdata[3:2]);
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(debounce_predict(s_tdata[2:0], s_tdata[3]));
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("multi_channel_edge_debouncer_unit regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= no_stall || ($urandom_range(99) >= 20);
    end

    task automatic send_sample(input int ch, input logic lvl);
        @(negedge clk);
        while (!no_gap && $urandom_range(99) < 20)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, lvl, ch[2:0]};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops the sample stream and waits until every result has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_ENABLED:       cfg_enabled  = val[0];
            REG_CHANNEL_COUNT: cfg_channels = val[3:0];
            REG_REPEAT_COUNT:  cfg_repeat   = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_directed();
        // Disabled block ignores samples, even on channels out of range.
        send_sample(0, 1'b0);
        send_sample(7, 1'b1);
        reg_write(REG_CHANNEL_COUNT, 32'd2);
        send_sample(5, 1'b0);
        reg_write(REG_ENABLED, 32'd1);
        reg_write(REG_CHANNEL_COUNT, 32'd0);
        send_sample(0, 1'b1);
        reg_write(REG_CHANNEL_COUNT, 32'd8);
        reg_write(REG_REPEAT_COUNT, 32'd1);
        send_sample(0, 1'b1);
        send_sample(0, 1'b0);
        send_sample(0, 1'b0);
        send_sample(0, 1'b1);
        send_sample(0, 1'b1);
        send_sample(7, 1'b0);
        send_sample(7, 1'b0);
        // A count above the channel table leaves every channel usable.
        reg_write(REG_CHANNEL_COUNT, 32'd15);
        send_sample(6, 1'b0);
        send_sample(7, 1'b1);
        reg_write(REG_CHANNEL_COUNT, 32'd3);
        send_sample(3, 1'b0);
        send_sample(7, 1'b1);
        reg_write(REG_REPEAT_COUNT, 32'd2);
        send_sample(1, 1'b0);
        send_sample(1, 1'b1);
        send_sample(1, 1'b0);
        send_sample(1, 1'b0);
        send_sample(2, 1'b0);
    endtask

    // Lowering the repeat count to zero under a running counter takes a full
    // counter wrap to reach an edge.
    task automatic test_repeat_lowered();
        logic lvl;
        reg_write(REG_CHANNEL_COUNT, 32'd8);
        reg_write(REG_REPEAT_COUNT, 32'd8);
        lvl = steady_level(2);
        send_sample(2, lvl);
        repeat (5) send_sample(2, ~lvl);
        reg_write(REG_REPEAT_COUNT, 32'd0);
        repeat (252) send_sample(2, ~lvl);
    endtask

    task automatic test_random();
        int   sent;
        int   ch;
        int   run_len;
        int   top;
        logic lvl;
        bit   drained;
        for (int phase = 0; phase < 3; phase++)
        begin
            reg_write(REG_CHANNEL_COUNT,
                      ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(4, 8));
            reg_write(REG_REPEAT_COUNT,
                      ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(1, 5));
            no_gap   = (phase == 2);
            no_stall = (phase == 2);
            top  = (cfg_channels == 0) ? NUM_CH : ((cfg_channels > NUM_CH) ? NUM_CH
                                                                          : cfg_channels);
            sent    = 0;
            drained = 1'b0;
            while (sent < 60)
            begin
                if (phase == 1 && sent >= 30 && !drained)
                begin
                    drain();
                    drained = 1'b1;
                end
                if ($urandom_range(99) < 80)
                begin
                    // Burst of one level on one channel, of a length drawn up to
                    // the repeat count plus three, or up to eight above a repeat of six.
                    ch      = ($urandom_range(9) == 0) ? $urandom_range(7)
                                                       : $urandom_range(top - 1);
                    lvl     = $urandom_range(1);
                    run_len = $urandom_range(1, (cfg_repeat > 6) ? 8 : cfg_repeat + 3);
                    repeat (run_len) send_sample(ch, lvl);
                    sent += run_len;
                end
                else
                begin
                    send_sample($urandom_range(7), $urandom_range(1));
                    sent++;
                end
            end
        end
        no_gap   = 1'b0;
        no_stall = 1'b0;
    endtask

    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        no_gap   = 1'b0;
        no_stall = 1'b0;
        error_count = 0;
        cycle_count = 0;
        for (int k = 0; k < NUM_CH; k++)
        begin
            chan_state[k] = BTN_HIGH;
            chan_miss[k]  = 8'd0;
        end
        cfg_enabled  = 1'b0;
        cfg_channels = 4'd0;
        cfg_repeat   = 8'd4;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_repeat_lowered();
        test_random();

        drain();
        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("multi_channel_edge_debouncer_unit regression: pass");
        else
            $display("multi_channel_edge_debouncer_unit regression: fail");
        $finish;
    end

endmodule

// File: sim.f
sv/mced_pkg.sv
sv/mced_store.sv
sv/multi_channel_edge_debouncer_unit.sv
tb/tb_multi_channel_edge_debouncer_unit.sv
